/* sv/vncb_pkg.sv */
// Shared constants, codes and types for the Voronoi nearest-cell border block.
`timescale 1ns / 1ps

package vncb_pkg;

  localparam int unsigned MAX_GEN_DEF   = 16;
  localparam int unsigned COORD_W_DEF   = 16;
  localparam int unsigned CFG_DATA_W    = 16;
  localparam int unsigned CFG_IDX_W     = 1;
  localparam int unsigned BORDER_W      = 16;
  localparam int unsigned GEN_COUNT_W   = 5;
  localparam int unsigned GEN_COUNT_RST = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GEN_COUNT    = 1'b0,
    CFG_BORDER_WIDTH = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    MODE_LOAD  = 1'b0,
    MODE_QUERY = 1'b1
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_ROOT,
    ST_HOLD
  } state_e;

endpackage

/* sv/vncb_intf.sv */
// Valid/ready channel interfaces for load/query items and result items.
`timescale 1ns / 1ps

interface vncb_in_if #(
  parameter int unsigned IDX_W = $clog2(vncb_pkg::MAX_GEN_DEF),
  parameter int unsigned CW    = vncb_pkg::COORD_W_DEF
) ();
  logic                 valid;
  logic                 ready;
  logic                 mode;
  logic [IDX_W-1:0]     entry_index;
  logic signed [CW-1:0] coord_x;
  logic signed [CW-1:0] coord_y;
  logic signed [CW-1:0] coord_z;

  modport source (output valid, mode, entry_index, coord_x, coord_y, coord_z, input ready);
  modport sink   (input valid, mode, entry_index, coord_x, coord_y, coord_z, output ready);
endinterface

interface vncb_out_if #(
  parameter int unsigned IDX_W  = $clog2(vncb_pkg::MAX_GEN_DEF),
  parameter int unsigned DIST_W = vncb_pkg::COORD_W_DEF + 1
) ();
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  nearest_index;
  logic              is_border;
  logic [DIST_W-1:0] nearest_distance;

  modport source (output valid, nearest_index, is_border, nearest_distance, input ready);
  modport sink   (input valid, nearest_index, is_border, nearest_distance, output ready);
endinterface

/* sv/vncb_sqrt.sv */
// Iterative integer square root, two root bits per cycle.
`timescale 1ns / 1ps

module vncb_sqrt #(
  parameter int unsigned RW = vncb_pkg::COORD_W_DEF + 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [2*RW-1:0] radicand_i,
  output logic            done_o,
  output logic [RW-1:0]   root_o
);

  localparam int unsigned NSTEP = (RW + 1) / 2;
  localparam int unsigned PW    = 4 * NSTEP;
  localparam int unsigned QW    = 2 * NSTEP;
  localparam int unsigned REMW  = QW + 2;
  localparam int unsigned CNT_W = $clog2(NSTEP + 1);

  logic [PW-1:0]    rad_q;
  logic [REMW-1:0]  rem_q, rem_d;
  logic [QW-1:0]    root_q, root_d;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;

  // two restoring digit steps per cycle, radicand consumed from the top
  always_comb begin
    logic [REMW-1:0] trial;
    rem_d  = rem_q;
    root_d = root_q;
    trial  = '0;
    for (int k = 0; k < 2; k++) begin
      rem_d = {rem_d[REMW-3:0], rad_q[PW-1-2*k -: 2]};
      trial = {root_d, 2'b01};
      if (rem_d >= trial) begin
        rem_d  = rem_d - trial;
        root_d = {root_d[QW-2:0], 1'b1};
      end else begin
        root_d = {root_d[QW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(NSTEP);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= PW'(radicand_i);
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[PW-5:0], 4'b0000};
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign done_o = done_q;
  assign root_o = root_q[RW-1:0];

endmodule

/* sv/voronoi_nearest_cell_border.sv */
// Top level: generator store, distance pipeline and border classification.
//
//   channel  dir  handshake         payload
//   req_i    in   valid/ready       mode, entry_index, coord_x/y/z
//   rsp_o    out  valid/ready       nearest_index, is_border, nearest_distance
//   cfg      in   cfg_we_i only     cfg_index_i, cfg_data_i
//
// A load item is written straight into the store. A query makes one store read per
// generator through a three-stage distance pipeline, then runs two root units side by
// side, two bits a cycle; no new item is taken until its result is loaded.
// The store has no reset; entries read before being loaded give arbitrary results.
// A finished result sits in the output register; the next item is taken meanwhile.
`timescale 1ns / 1ps

module voronoi_nearest_cell_border #(
  parameter int unsigned MAX_GENERATORS = vncb_pkg::MAX_GEN_DEF,
  parameter int unsigned COORD_WIDTH    = vncb_pkg::COORD_W_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [vncb_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [vncb_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  vncb_in_if.sink                               req_i,
  vncb_out_if.source                            rsp_o
);

  localparam int unsigned IDX_W   = $clog2(MAX_GENERATORS);
  localparam int unsigned CNT_W   = $clog2(MAX_GENERATORS + 1);
  localparam int unsigned GC_W    = vncb_pkg::GEN_COUNT_W;
  localparam int unsigned CLAMP_W = (CNT_W > GC_W) ? CNT_W : GC_W;
  localparam int unsigned CW      = COORD_WIDTH;
  localparam int unsigned RW      = CW + 1;
  localparam int unsigned SQ_W    = 2 * RW;
  localparam int unsigned PROD_W  = 2 * CW;
  localparam int unsigned ENT_W   = 3 * CW;
  localparam int unsigned BW      = vncb_pkg::BORDER_W;
  localparam int unsigned CMP_W   = (RW > BW) ? RW : BW;

  function automatic logic [CW-1:0] abs_diff(input logic signed [CW-1:0] a,
                                             input logic signed [CW-1:0] b);
    logic signed [CW:0] d;
    d = {a[CW-1], a} - {b[CW-1], b};
    return d[CW] ? CW'(-d) : d[CW-1:0];
  endfunction

  // configuration
  logic [GC_W-1:0] gen_count_q;
  logic [BW-1:0]   border_width_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_count_q    <= GC_W'(vncb_pkg::GEN_COUNT_RST);
      border_width_q <= '0;
    end else if (cfg_we_i) begin
      unique case (vncb_pkg::cfg_reg_e'(cfg_index_i))
        vncb_pkg::CFG_GEN_COUNT:    gen_count_q    <= cfg_data_i[GC_W-1:0];
        vncb_pkg::CFG_BORDER_WIDTH: border_width_q <= cfg_data_i[BW-1:0];
      endcase
    end
  end

  // control
  vncb_pkg::state_e state_q, state_d;
  logic [CNT_W-1:0] rd_idx_q, rd_idx_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             req_fire, is_query, mem_we, rd_en, sqrt_start, out_load;
  logic             sqrt1_done, sqrt2_done;
  logic             out_valid_q;

  logic signed [CW-1:0] px_q, py_q, pz_q;

  logic [ENT_W-1:0] gen_store_q [MAX_GENERATORS];
  logic [ENT_W-1:0] rd_data_q;
  logic             v1_q, v2_q;
  logic [IDX_W-1:0] idx1_q, idx2_q;
  logic [PROD_W-1:0] sqx_q, sqy_q, sqz_q;

  logic             have_best_q, have_second_q;
  logic [SQ_W-1:0]  best_sq_q, second_sq_q;
  logic [IDX_W-1:0] best_idx_q;

  logic [RW-1:0]    root1, root2;
  logic [RW-1:0]    gap;
  logic             border;

  assign req_fire = req_i.valid && req_i.ready;
  assign is_query = (req_i.mode == vncb_pkg::MODE_QUERY);
  assign mem_we   = req_fire && !is_query &&
                    (CNT_W'(req_i.entry_index) < CNT_W'(MAX_GENERATORS));

  always_comb begin
    state_d      = state_q;
    rd_idx_d     = rd_idx_q;
    count_d      = count_q;
    req_i.ready  = 1'b0;
    rd_en        = 1'b0;
    sqrt_start   = 1'b0;
    out_load     = 1'b0;
    unique case (state_q)
      vncb_pkg::ST_IDLE: begin
        req_i.ready = 1'b1;
        if (req_fire && is_query) begin
          rd_idx_d = '0;
          if (gen_count_q == '0) begin
            count_d = CNT_W'(1);
          end else if (CLAMP_W'(gen_count_q) > CLAMP_W'(MAX_GENERATORS)) begin
            count_d = CNT_W'(MAX_GENERATORS);
          end else begin
            count_d = CNT_W'(gen_count_q);
          end
          state_d = vncb_pkg::ST_SCAN;
        end
      end
      vncb_pkg::ST_SCAN: begin
        rd_en    = 1'b1;
        rd_idx_d = rd_idx_q + CNT_W'(1);
        if (rd_idx_q == count_q - CNT_W'(1)) begin
          state_d = vncb_pkg::ST_DRAIN;
        end
      end
      vncb_pkg::ST_DRAIN: begin
        // last distance has been folded in once both stages are empty
        if (!v1_q && !v2_q) begin
          sqrt_start = 1'b1;
          state_d    = vncb_pkg::ST_ROOT;
        end
      end
      vncb_pkg::ST_ROOT: begin
        if (sqrt1_done) begin
          state_d = vncb_pkg::ST_HOLD;
        end
      end
      vncb_pkg::ST_HOLD: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_load = 1'b1;
          state_d  = vncb_pkg::ST_IDLE;
        end
      end
      default: state_d = vncb_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= vncb_pkg::ST_IDLE;
      rd_idx_q    <= '0;
      count_q     <= CNT_W'(1);
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_idx_q <= rd_idx_d;
      count_q  <= count_d;
      v1_q     <= rd_en;
      v2_q     <= v1_q;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // generator store, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      gen_store_q[req_i.entry_index] <= {req_i.coord_x, req_i.coord_y, req_i.coord_z};
    end
    if (rd_en) begin
      rd_data_q <= gen_store_q[rd_idx_q[IDX_W-1:0]];
    end
  end

  // sample point and distance pipeline
  always_ff @(posedge clk_i) begin
    if (req_fire && is_query) begin
      px_q <= req_i.coord_x;
      py_q <= req_i.coord_y;
      pz_q <= req_i.coord_z;
    end
    idx1_q <= rd_idx_q[IDX_W-1:0];
    if (v1_q) begin
      logic [CW-1:0] ax, ay, az;
      ax = abs_diff(rd_data_q[3*CW-1:2*CW], px_q);
      ay = abs_diff(rd_data_q[2*CW-1:CW], py_q);
      az = abs_diff(rd_data_q[CW-1:0], pz_q);
      sqx_q  <= PROD_W'(ax) * PROD_W'(ax);
      sqy_q  <= PROD_W'(ay) * PROD_W'(ay);
      sqz_q  <= PROD_W'(az) * PROD_W'(az);
      idx2_q <= idx1_q;
    end
  end

  // running best two, in index order so lower index keeps ties
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_best_q   <= 1'b0;
      have_second_q <= 1'b0;
    end else if (req_fire && is_query) begin
      have_best_q   <= 1'b0;
      have_second_q <= 1'b0;
    end else if (v2_q) begin
      logic [SQ_W-1:0] sum;
      sum = SQ_W'(sqx_q) + SQ_W'(sqy_q) + SQ_W'(sqz_q);
      if (!have_best_q || sum < best_sq_q) begin
        if (have_best_q) begin
          have_second_q <= 1'b1;
        end
        have_best_q <= 1'b1;
      end else if (!have_second_q || sum < second_sq_q) begin
        have_second_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (v2_q) begin
      logic [SQ_W-1:0] sum;
      sum = SQ_W'(sqx_q) + SQ_W'(sqy_q) + SQ_W'(sqz_q);
      if (!have_best_q || sum < best_sq_q) begin
        if (have_best_q) begin
          second_sq_q <= best_sq_q;
        end
        best_sq_q  <= sum;
        best_idx_q <= idx2_q;
      end else if (!have_second_q || sum < second_sq_q) begin
        second_sq_q <= sum;
      end
    end
  end

  vncb_sqrt #(.RW(RW)) u_sqrt_near (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start),
    .radicand_i (best_sq_q),
    .done_o     (sqrt1_done),
    .root_o     (root1)
  );

  vncb_sqrt #(.RW(RW)) u_sqrt_second (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start),
    .radicand_i (second_sq_q),
    .done_o     (sqrt2_done),
    .root_o     (root2)
  );

  assign gap    = root2 - root1;
  assign border = have_second_q && (CMP_W'(gap) <= CMP_W'(border_width_q));

  // output register
  logic [IDX_W-1:0] out_idx_q;
  logic             out_border_q;
  logic [RW-1:0]    out_dist_q;

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_idx_q    <= best_idx_q;
      out_border_q <= border;
      out_dist_q   <= root1;
    end
  end

  assign rsp_o.valid            = out_valid_q;
  assign rsp_o.nearest_index    = out_idx_q;
  assign rsp_o.is_border        = out_border_q;
  assign rsp_o.nearest_distance = out_dist_q;

`ifndef SYNTHESIS
  a_best_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    have_second_q |-> best_sq_q <= second_sq_q)
    else $error("second-nearest distance below nearest");

  a_start_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sqrt_start |-> (!v1_q && !v2_q && have_best_q))
    else $error("root started before distance pipeline drained");

  a_roots_together: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sqrt1_done == sqrt2_done)
    else $error("root units out of step");

  a_root_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == vncb_pkg::ST_HOLD && have_second_q) |-> root2 >= root1)
    else $error("second root below nearest root");

  a_best_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == vncb_pkg::ST_HOLD) |-> CNT_W'(best_idx_q) < count_q)
    else $error("nearest index beyond generator count");
`endif

endmodule
